// ----- sv/script_token_lexer_top_assert.svh -----
// Assertion macros for the script token lexer.
// Used by script_token_lexer_top.sv; expects clk and rst_n in scope.
`ifndef SCRIPT_TOKEN_LEXER_TOP_ASSERT_SVH
`define SCRIPT_TOKEN_LEXER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STLEX_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define STLEX_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/stlex_pkg.sv -----
// Shared types, constants and character helpers for the script token lexer.
// No dependencies; used by script_token_lexer_top.sv.
package stlex_pkg;

  localparam int MAX_TOKEN_LEN = 16;
  localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int ADDR_W        = $clog2(MAX_TOKEN_LEN);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TOKEN_LEN);

  typedef enum logic [3:0] {
    KIND_END    = 4'd0,
    KIND_LET    = 4'd1,
    KIND_SHOW   = 4'd2,
    KIND_NUMBER = 4'd3,
    KIND_IDENT  = 4'd4,
    KIND_PLUS   = 4'd5,
    KIND_MINUS  = 4'd6,
    KIND_EQUALS = 4'd7,
    KIND_SEMI   = 4'd8,
    KIND_ERROR  = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_NUM     = 2'd1,
    MODE_IDENT   = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       no_char;
    logic       src_last;
  } in_item_t;

  typedef struct packed {
    kind_t      token_kind;
    logic [7:0] text_byte;
    logic       text_last;
    logic       truncated;
    logic       run_last;
  } out_item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Single-character token kind; anything unlisted is an error
  function automatic kind_t sym_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h3D:   k = KIND_EQUALS;
      8'h3B:   k = KIND_SEMI;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // Does byte c match "let" at position idx
  function automatic logic kw_let_hit(input logic [CNT_W-1:0] idx, input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (idx == CNT_W'(0)) hit = (c == 8'h6C);
    if (idx == CNT_W'(1)) hit = (c == 8'h65);
    if (idx == CNT_W'(2)) hit = (c == 8'h74);
    return hit;
  endfunction

  // Does byte c match "show" at position idx
  function automatic logic kw_show_hit(input logic [CNT_W-1:0] idx, input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (idx == CNT_W'(0)) hit = (c == 8'h73);
    if (idx == CNT_W'(1)) hit = (c == 8'h68);
    if (idx == CNT_W'(2)) hit = (c == 8'h6F);
    if (idx == CNT_W'(3)) hit = (c == 8'h77);
    return hit;
  endfunction

endpackage

// ----- sv/stlex_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the token text buffer.
module stlex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/script_token_lexer_top.sv -----
// Top level of the script token lexer: scan control, run buffer and result register.
// Depends on stlex_pkg, stlex_ram and script_token_lexer_top_assert.svh.
//
//   channel | ports                         | payload
//   in      | in_valid, in_stall, in_data   | stlex_pkg::in_item_t  (ch, no_char, src_last)
//   out     | out_valid, out_stall, out_data| stlex_pkg::out_item_t (kind, byte, flags)
//
// A byte that extends a run is written straight into the buffer RAM; whitespace outside a run is dropped.
// A run ending reads the run out of the buffer RAM at one address per cycle while the output
// is not stalled; a symbol, error or END result is sent from S_POST, where a run started by
// the byte that ended the old one is also opened. No clearing pass: the buffer is only read below the fill count.
// Reset is synchronous, active low, and clears all control state.
// A stalled result holds in the output register; input is taken only between items.
module script_token_lexer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stlex_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stlex_pkg::out_item_t out_data
);

`include "script_token_lexer_top_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FLUSH = 3'b010,
    S_POST  = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  stlex_pkg::mode_t                mode_r, mode_nxt;
  logic [stlex_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            let_ok_r, let_ok_nxt;
  logic                            show_ok_r, show_ok_nxt;
  logic [7:0]                      ch_r, ch_nxt;
  logic                            last_r, last_nxt;
  logic                            sym_pend_r, sym_pend_nxt;
  stlex_pkg::kind_t                sym_kind_r, sym_kind_nxt;
  logic                            start_pend_r, start_pend_nxt;
  logic                            end_pend_r, end_pend_nxt;
  logic                            digit_next_r, digit_next_nxt;
  logic [stlex_pkg::CNT_W-1:0]     fidx_r, fidx_nxt;
  logic                            rd_pend_r, rd_pend_nxt;
  logic                            out_valid_r;
  stlex_pkg::out_item_t            out_data_r;

  // Buffer RAM ports
  logic                            ram_wr_en;
  logic [stlex_pkg::ADDR_W-1:0]    ram_wr_addr;
  logic [7:0]                      ram_wr_data;
  logic                            ram_rd_en;
  logic [stlex_pkg::ADDR_W-1:0]    ram_rd_addr;
  logic [7:0]                      ram_rd_data;

  // Decoded input and control helpers
  logic                            accept;
  logic                            can_load;
  logic                            load;
  stlex_pkg::out_item_t            load_data;
  logic                            in_has_char;
  logic                            in_digit;
  logic                            in_alpha;
  logic                            in_sym;
  logic                            in_err;
  logic                            in_cont;
  logic                            run_open;
  logic                            fire;
  logic                            more_rd;
  stlex_pkg::kind_t                flush_kind;
  logic                            kw_let;
  logic                            kw_show;

  // Append request into the run buffer
  logic                            app_en;
  logic                            app_fresh;
  logic [7:0]                      app_ch;
  logic [stlex_pkg::CNT_W-1:0]     app_base;

  stlex_ram #(
    .WIDTH (8),
    .DEPTH (stlex_pkg::MAX_TOKEN_LEN)
  ) u_buf (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign can_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Classify the incoming byte
  assign in_has_char = !in_data.no_char;
  assign in_digit    = stlex_pkg::is_digit(in_data.ch);
  assign in_alpha    = stlex_pkg::is_alpha(in_data.ch);
  assign in_sym      = in_has_char && !in_digit && !in_alpha && !stlex_pkg::is_space(in_data.ch);
  assign in_err      = in_sym && (stlex_pkg::sym_kind(in_data.ch) == stlex_pkg::KIND_ERROR);
  assign in_cont     = in_has_char &&
                       (((mode_r == stlex_pkg::MODE_NUM) && in_digit) ||
                        ((mode_r == stlex_pkg::MODE_IDENT) && in_alpha));
  assign run_open    = (mode_r == stlex_pkg::MODE_NUM) || (mode_r == stlex_pkg::MODE_IDENT);

  // Kind of the buffered run; keywords only when untruncated and not followed by a digit
  assign kw_let  = !ovf_r && !digit_next_r && let_ok_r && (count_r == stlex_pkg::CNT_W'(3));
  assign kw_show = !ovf_r && !digit_next_r && show_ok_r && (count_r == stlex_pkg::CNT_W'(4));

  always_comb begin
    if (mode_r == stlex_pkg::MODE_IDENT) begin
      if (kw_let) begin
        flush_kind = stlex_pkg::KIND_LET;
      end else if (kw_show) begin
        flush_kind = stlex_pkg::KIND_SHOW;
      end else begin
        flush_kind = stlex_pkg::KIND_IDENT;
      end
    end else begin
      flush_kind = stlex_pkg::KIND_NUMBER;
    end
  end

  // Readout handshake with the RAM: a read in flight waits for the output register
  assign fire    = (state_r == S_FLUSH) && rd_pend_r && can_load;
  assign more_rd = fidx_r < count_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    let_ok_nxt     = let_ok_r;
    show_ok_nxt    = show_ok_r;
    ch_nxt         = ch_r;
    last_nxt       = last_r;
    sym_pend_nxt   = sym_pend_r;
    sym_kind_nxt   = sym_kind_r;
    start_pend_nxt = start_pend_r;
    end_pend_nxt   = end_pend_r;
    digit_next_nxt = digit_next_r;
    fidx_nxt       = fidx_r;
    rd_pend_nxt    = rd_pend_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = '0;
    ram_wr_data    = '0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = fidx_r[stlex_pkg::ADDR_W-1:0];
    load           = 1'b0;
    load_data      = '0;
    app_en         = 1'b0;
    app_fresh      = 1'b0;
    app_ch         = ch_r;
    app_base       = count_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ch_nxt   = in_data.ch;
          last_nxt = in_data.src_last;
          if (mode_r == stlex_pkg::MODE_DISCARD) begin
            // drop everything up to the end of the source
            if (in_data.src_last) begin
              mode_nxt = stlex_pkg::MODE_IDLE;
            end
          end else if (in_cont) begin
            // extend the current run
            app_en = 1'b1;
            app_ch = in_data.ch;
            if (in_data.src_last) begin
              end_pend_nxt   = 1'b1;
              digit_next_nxt = 1'b0;
              fidx_nxt       = '0;
              rd_pend_nxt    = 1'b0;
              state_nxt      = S_FLUSH;
            end
          end else begin
            sym_pend_nxt   = in_sym;
            sym_kind_nxt   = stlex_pkg::sym_kind(in_data.ch);
            end_pend_nxt   = in_data.src_last && !in_err;
            digit_next_nxt = in_has_char && in_digit;
            if (run_open && (in_has_char || in_data.src_last)) begin
              // send the old run first; an empty item keeps the run open
              start_pend_nxt = in_has_char && (in_digit || in_alpha);
              fidx_nxt       = '0;
              rd_pend_nxt    = 1'b0;
              state_nxt      = S_FLUSH;
            end else begin
              start_pend_nxt = 1'b0;
              if (in_has_char && (in_digit || in_alpha)) begin
                // open a new run right away
                app_en    = 1'b1;
                app_fresh = 1'b1;
                app_ch    = in_data.ch;
                if (in_data.src_last) begin
                  digit_next_nxt = 1'b0;
                  fidx_nxt       = '0;
                  rd_pend_nxt    = 1'b0;
                  state_nxt      = S_FLUSH;
                end
              end else if (in_sym || in_data.src_last) begin
                state_nxt = S_POST;
              end
            end
          end
        end
      end

      S_FLUSH: begin
        if (fire) begin
          load                 = 1'b1;
          load_data.token_kind = flush_kind;
          load_data.text_byte  = ram_rd_data;
          load_data.text_last  = !more_rd;
          load_data.truncated  = ovf_r;
          load_data.run_last   = !more_rd && !sym_pend_r && !end_pend_r;
        end
        // issue the next read once the previous byte has left
        if (more_rd && (!rd_pend_r || fire)) begin
          ram_rd_en   = 1'b1;
          fidx_nxt    = fidx_r + stlex_pkg::CNT_W'(1);
          rd_pend_nxt = 1'b1;
        end else if (fire) begin
          rd_pend_nxt = 1'b0;
        end
        if (fire && !more_rd) begin
          mode_nxt  = stlex_pkg::MODE_IDLE;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = (sym_pend_r || start_pend_r || end_pend_r) ? S_POST : S_IDLE;
        end
      end

      S_POST: begin
        if (sym_pend_r) begin
          // symbol or error result
          if (can_load) begin
            load                 = 1'b1;
            load_data.token_kind = sym_kind_r;
            load_data.text_byte  = ch_r;
            load_data.text_last  = 1'b1;
            load_data.truncated  = 1'b0;
            load_data.run_last   = !end_pend_r;
            sym_pend_nxt         = 1'b0;
            if (sym_kind_r == stlex_pkg::KIND_ERROR) begin
              mode_nxt = last_r ? stlex_pkg::MODE_IDLE : stlex_pkg::MODE_DISCARD;
            end
            if (!end_pend_r) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (start_pend_r) begin
          // open the run started by the byte that ended the old one
          app_en         = 1'b1;
          app_fresh      = 1'b1;
          app_ch         = ch_r;
          start_pend_nxt = 1'b0;
          if (end_pend_r) begin
            digit_next_nxt = 1'b0;
            fidx_nxt       = '0;
            rd_pend_nxt    = 1'b0;
            state_nxt      = S_FLUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (end_pend_r) begin
          if (can_load) begin
            load                 = 1'b1;
            load_data.token_kind = stlex_pkg::KIND_END;
            load_data.text_byte  = 8'h00;
            load_data.text_last  = 1'b1;
            load_data.truncated  = 1'b0;
            load_data.run_last   = 1'b1;
            end_pend_nxt         = 1'b0;
            state_nxt            = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Append one byte to the run buffer, or mark the run truncated when full
    if (app_en) begin
      app_base = app_fresh ? '0 : count_r;
      if (app_fresh) begin
        mode_nxt = stlex_pkg::is_digit(app_ch) ? stlex_pkg::MODE_NUM : stlex_pkg::MODE_IDENT;
        ovf_nxt  = 1'b0;
      end
      if (app_base < stlex_pkg::MAX_CNT) begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = app_base[stlex_pkg::ADDR_W-1:0];
        ram_wr_data = app_ch;
        count_nxt   = app_base + stlex_pkg::CNT_W'(1);
        let_ok_nxt  = ((app_base == '0) || let_ok_r) &&
                      stlex_pkg::kw_let_hit(app_base, app_ch);
        show_ok_nxt = ((app_base == '0) || show_ok_r) &&
                      stlex_pkg::kw_show_hit(app_base, app_ch);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= stlex_pkg::MODE_IDLE;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      sym_pend_r   <= 1'b0;
      start_pend_r <= 1'b0;
      end_pend_r   <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      sym_pend_r   <= sym_pend_nxt;
      start_pend_r <= start_pend_nxt;
      end_pend_r   <= end_pend_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= load || (out_valid_r && out_stall);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    let_ok_r     <= let_ok_nxt;
    show_ok_r    <= show_ok_nxt;
    ch_r         <= ch_nxt;
    last_r       <= last_nxt;
    sym_kind_r   <= sym_kind_nxt;
    digit_next_r <= digit_next_nxt;
    fidx_r       <= fidx_nxt;
    if (load) begin
      out_data_r <= load_data;
    end
  end

  // Checks
  `STLEX_CHK(a_buf_port_split, ram_wr_en, !ram_rd_en, "buffer written during readout")
  `STLEX_CHK(a_count_bound, 1'b1, count_r <= stlex_pkg::MAX_CNT, "run count above buffer size")
  `STLEX_CHK(a_ovf_full, ovf_r, count_r == stlex_pkg::MAX_CNT, "truncation without a full buffer")
  `STLEX_CHK(a_flush_has_run, state_r == S_FLUSH, run_open && (count_r != '0), "readout of an empty run")
  `STLEX_CHK_NEXT(a_discard_quiet, (mode_r == stlex_pkg::MODE_DISCARD) && !out_valid_r, !out_valid_r, "result while discarding")

endmodule
